### design/assert_macros.svh
// Assertion macros used by the checker file of the packet ring store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define NPR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define NPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/npr_pkg.sv
// Package with the types and constants of the packet ring store.
`default_nettype none

package npr_pkg;

    localparam int SEQ_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int LENO_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 11;
    localparam int MODE_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_NONE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SCAN_DONE,
        ST_RB_ADDR,
        ST_RB_READ,
        ST_RB_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr_all;
    } tab_ctl_t;

endpackage

`default_nettype wire

### design/numbered_packet_ring_store_unit.sv
// Top level of the sequence-numbered packet ring store.
//
// The input stream carries one command item per handshake: s_tuser selects the
// mode, s_tlast marks the final byte of a stored packet. Mode 0 writes one
// packet byte into the current ring slot; the final byte commits the slot and
// returns the assigned sequence number. Mode 1 returns the next stored number
// above a query, mode 2 finds a slot by number, mode 3 reads one stored byte.
// Non-final bytes of mode 0 produce no result item.
// Steps: a mode 0 item runs a put step and a mode 3 item an address, a read
// and a result step; in modes 1 and 2 the scan walks the slot table one
// entry per read-and-compare pair, then a result step follows. The table and
// packet memory each have one registered read port. s_tready is low while
// an item is being worked on.
// A result waits in an output register, so the next item is taken while the
// receiver stalls; the block only holds in its last step when a second result
// is ready before the first has been taken. Reset empties all slots at once
// through valid bits, clears the running number, write slot and output valid;
// packet memory is left as it is.
`default_nettype none

module numbered_packet_ring_store_unit #(
    parameter int              SLOTS     = 16,
    parameter int              PKT_BYTES = 2048,
    parameter longint unsigned SEQ_LIMIT = 65535
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // data_byte[7:0], seq_query[23:8], slot_sel[27:24], byte_offset[38:28], zero[39]
    input  logic [npr_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  logic [npr_pkg::MODE_W-1:0]       s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // seq_out[15:0], slot_out[19:16], length_out[31:20], byte_out[39:32]
    output logic [npr_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[0]
    output logic                             m_tuser
);

    import npr_pkg::*;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int LEN_W     = $clog2(PKT_BYTES + 1);
    localparam int NUM_W     = $clog2(SEQ_LIMIT + 1);
    localparam int CMP_W     = (NUM_W > SEQ_W) ? NUM_W : SEQ_W;
    localparam int MEM_DEPTH = SLOTS * PKT_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [SEQ_W-1:0]   SEQ_NONE  = SEQ_W'(SEQ_LIMIT);
    localparam logic [NUM_W:0]     NUM_LIMIT = (NUM_W + 1)'(SEQ_LIMIT);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0]  SLOT_SPAN = ADDR_W'(PKT_BYTES);

    state_t state_reg, state_next;

    // Latched input item.
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [SEQ_W-1:0]  query_reg, query_next;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    // Ring state.
    logic [NUM_W-1:0]  latest_reg, latest_next;
    logic [IDX_W-1:0]  wslot_reg, wslot_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic              in_pkt_reg, in_pkt_next;

    // Scan and read sequencing.
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [NUM_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [LEN_W-1:0]  hit_len_reg, hit_len_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [SEQ_W-1:0]  m_seq_reg, m_seq_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic [LENO_W-1:0] m_len_reg, m_len_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;

    // Packet memory.
    logic [BYTE_W-1:0] pkt_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_byte_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;

    // Slot table port.
    tab_ctl_t          tab_ctl;
    logic [IDX_W-1:0]  tab_wr_idx;
    logic [NUM_W-1:0]  tab_wr_num;
    logic [LEN_W-1:0]  tab_wr_len;
    logic [IDX_W-1:0]  tab_rd_idx;
    logic [NUM_W-1:0]  tab_rd_num;
    logic [LEN_W-1:0]  tab_rd_len;

    // Working values of the put step.
    logic              first_byte;
    logic [NUM_W:0]    num_inc;
    logic              wrap;
    logic [NUM_W-1:0]  cur_num;
    logic [IDX_W-1:0]  cur_slot;
    logic [ADDR_W-1:0] cur_base;
    logic [LEN_W-1:0]  cur_fill;
    logic              fill_room;
    logic [LEN_W-1:0]  fill_new;

    // Shared compare operands of the scan.
    logic [CMP_W-1:0]  cmp_num;
    logic [CMP_W-1:0]  cmp_query;
    logic [CMP_W-1:0]  cmp_best;

    logic              out_free;
    logic              sel_ok;
    logic              off_in_pkt;
    logic              off_in_len;

    npr_slot_tab #(
        .SLOTS (SLOTS),
        .NUM_W (NUM_W),
        .LEN_W (LEN_W)
    ) u_tab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tab_ctl),
        .wr_idx  (tab_wr_idx),
        .wr_num  (tab_wr_num),
        .wr_len  (tab_wr_len),
        .rd_idx  (tab_rd_idx),
        .rd_num  (tab_rd_num),
        .rd_len  (tab_rd_len)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    assign first_byte = !in_pkt_reg;
    assign num_inc    = {1'b0, latest_reg} + (NUM_W + 1)'(1);
    assign wrap       = first_byte && (num_inc == NUM_LIMIT);
    assign cur_num    = first_byte ? (wrap ? '0 : NUM_W'(num_inc)) : latest_reg;
    assign cur_slot   = wrap ? '0 : wslot_reg;
    assign cur_base   = wrap ? '0 : base_reg;
    assign cur_fill   = first_byte ? '0 : fill_reg;
    assign fill_room  = 32'(cur_fill) < 32'(PKT_BYTES);
    assign fill_new   = fill_room ? cur_fill + LEN_W'(1) : cur_fill;
    assign mem_waddr  = cur_base + ADDR_W'(cur_fill);

    assign cmp_num    = CMP_W'(tab_rd_num);
    assign cmp_query  = CMP_W'(query_reg);
    assign cmp_best   = CMP_W'(best_reg);

    assign sel_ok     = 32'(sel_reg) < 32'(SLOTS);
    assign off_in_pkt = 32'(off_reg) < 32'(PKT_BYTES);
    assign off_in_len = 32'(off_reg) < 32'(tab_rd_len);

    assign tab_rd_idx = (state_reg == ST_RB_ADDR) ? IDX_W'(sel_reg) : idx_reg;
    assign tab_wr_idx = cur_slot;
    assign tab_wr_num = cur_num;
    assign tab_wr_len = fill_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        query_next    = query_reg;
        sel_next      = sel_reg;
        off_next      = off_reg;
        latest_next   = latest_reg;
        wslot_next    = wslot_reg;
        base_next     = base_reg;
        fill_next     = fill_reg;
        in_pkt_next   = in_pkt_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        hit_idx_next  = hit_idx_reg;
        hit_len_next  = hit_len_reg;
        rd_addr_next  = rd_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_seq_next    = m_seq_reg;
        m_slot_next   = m_slot_reg;
        m_len_next    = m_len_reg;
        m_byte_next   = m_byte_reg;
        tab_ctl       = '0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tuser;
                    byte_next  = s_tdata[7:0];
                    last_next  = s_tlast;
                    query_next = s_tdata[23:8];
                    sel_next   = s_tdata[27:24];
                    off_next   = s_tdata[38:28];
                    idx_next   = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    hit_idx_next = '0;
                    hit_len_next = '0;
                    case (s_tuser)
                        MODE_PUT:    state_next = ST_PUT;
                        MODE_NEXT:   state_next = ST_SCAN_RD;
                        MODE_LOOKUP: state_next = ST_SCAN_RD;
                        default:     state_next = ST_RB_ADDR;
                    endcase
                end
            end
            ST_PUT: begin
                // A final byte must find the output register free before any
                // state changes, so the whole step waits for it.
                if (!last_reg || out_free) begin
                    tab_ctl.clr_all = wrap;
                    mem_we          = fill_room;
                    latest_next     = cur_num;
                    if (last_reg) begin
                        tab_ctl.wr_en = 1'b1;
                        if (cur_slot == IDX_LAST) begin
                            wslot_next = '0;
                            base_next  = '0;
                        end else begin
                            wslot_next = cur_slot + IDX_W'(1);
                            base_next  = cur_base + SLOT_SPAN;
                        end
                        fill_next     = '0;
                        in_pkt_next   = 1'b0;
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_OK;
                        m_seq_next    = SEQ_W'(cur_num);
                        m_slot_next   = '0;
                        m_len_next    = '0;
                        m_byte_next   = '0;
                    end else begin
                        wslot_next  = cur_slot;
                        base_next   = cur_base;
                        fill_next   = fill_new;
                        in_pkt_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                tab_ctl.rd_en = 1'b1;
                state_next    = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL: begin
                if (mode_reg == MODE_NEXT) begin
                    if (cmp_num > cmp_query && (!found_reg || cmp_num < cmp_best)) begin
                        found_next = 1'b1;
                        best_next  = tab_rd_num;
                    end
                end else begin
                    if (!found_reg && cmp_num == cmp_query) begin
                        found_next   = 1'b1;
                        hit_idx_next = idx_reg;
                        hit_len_next = tab_rd_len;
                    end
                end
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_SCAN_DONE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = found_reg ? STAT_OK : STAT_NONE;
                    m_byte_next   = '0;
                    if (mode_reg == MODE_NEXT) begin
                        m_seq_next  = found_reg ? SEQ_W'(best_reg) : SEQ_NONE;
                        m_slot_next = '0;
                        m_len_next  = '0;
                    end else begin
                        m_seq_next  = '0;
                        m_slot_next = found_reg ? SLOT_W'(hit_idx_reg) : '0;
                        m_len_next  = found_reg ? LENO_W'(hit_len_reg) : '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RB_ADDR: begin
                tab_ctl.rd_en = 1'b1;
                rd_addr_next  = (sel_ok && off_in_pkt) ?
                    ADDR_W'(32'(sel_reg) * 32'(PKT_BYTES) + 32'(off_reg)) : '0;
                state_next    = ST_RB_READ;
            end
            ST_RB_READ: begin
                mem_re     = 1'b1;
                state_next = ST_RB_DONE;
            end
            ST_RB_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = (sel_ok && off_in_len) ? STAT_OK : STAT_NONE;
                    m_seq_next    = '0;
                    m_slot_next   = '0;
                    m_len_next    = '0;
                    m_byte_next   = (sel_ok && off_in_len) ? rd_byte_reg : '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latest_reg  <= '0;
            wslot_reg   <= '0;
            base_reg    <= '0;
            fill_reg    <= '0;
            in_pkt_reg  <= 1'b0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            latest_reg  <= latest_next;
            wslot_reg   <= wslot_next;
            base_reg    <= base_next;
            fill_reg    <= fill_next;
            in_pkt_reg  <= in_pkt_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        query_reg    <= query_next;
        sel_reg      <= sel_next;
        off_reg      <= off_next;
        best_reg     <= best_next;
        hit_idx_reg  <= hit_idx_next;
        hit_len_reg  <= hit_len_next;
        rd_addr_reg  <= rd_addr_next;
        m_status_reg <= m_status_next;
        m_seq_reg    <= m_seq_next;
        m_slot_reg   <= m_slot_next;
        m_len_reg    <= m_len_next;
        m_byte_reg   <= m_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pkt_mem[mem_waddr] <= byte_reg;
        end
        if (mem_re) begin
            rd_byte_reg <= pkt_mem[rd_addr_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_byte_reg, m_len_reg, m_slot_reg, m_seq_reg};

endmodule

`default_nettype wire

### design/npr_slot_tab.sv
// Slot table: sequence number and length per slot, with valid bits for bulk clear.
`default_nettype none

module npr_slot_tab #(
    parameter int SLOTS = 16,
    parameter int NUM_W = 16,
    parameter int LEN_W = 12,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  npr_pkg::tab_ctl_t  ctl,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [NUM_W-1:0]   wr_num,
    input  logic [LEN_W-1:0]   wr_len,
    input  logic [IDX_W-1:0]   rd_idx,
    output logic [NUM_W-1:0]   rd_num,
    output logic [LEN_W-1:0]   rd_len
);

    logic [NUM_W-1:0] num_mem [SLOTS];
    logic [LEN_W-1:0] len_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_W-1:0] rd_num_reg;
    logic [LEN_W-1:0] rd_len_reg;

    // A clear and a write in the same cycle leave only the written slot valid.
    always_comb begin
        valid_next = ctl.clr_all ? '0 : valid_reg;
        if (ctl.wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    // A slot that is not valid reads as number zero and length zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            num_mem[wr_idx] <= wr_num;
            len_mem[wr_idx] <= wr_len;
        end
        if (ctl.rd_en) begin
            rd_num_reg <= valid_reg[rd_idx] ? num_mem[rd_idx] : '0;
            rd_len_reg <= valid_reg[rd_idx] ? len_mem[rd_idx] : '0;
        end
    end

    assign rd_num = rd_num_reg;
    assign rd_len = rd_len_reg;

endmodule

`default_nettype wire

### design/npr_checker.sv
// Port-level checker for the packet ring store, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module npr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [npr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);

    import npr_pkg::*;

    // A stalled result keeps its value until it is taken.
    `NPR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Every accepted item leaves the sequencer busy, so s_tready falls after each accept.
    `NPR_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready stayed high after accepting an item")

    // A new result is only produced from a working step, never from idle.
    `NPR_ASSERT(a_result_from_work, aclk, aresetn, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without an item in work")

    // A miss or a bad read carries no slot or length.
    `NPR_ASSERT(a_miss_fields_zero, aclk, aresetn, m_tvalid && (m_tuser == STAT_NONE) |-> m_tdata[31:16] == 16'd0, "miss result with slot or length set")

    // Reset leaves no result pending.
    `NPR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind numbered_packet_ring_store_unit npr_checker u_npr_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the sequence-numbered packet ring store.
`timescale 1ns / 100ps

module testbench;
    import npr_pkg::*;

    localparam int              SLOTS        = 16;
    localparam int              PKT_BYTES    = 2048;
    localparam int unsigned     SEQ_LIMIT    = 65535;
    localparam int              STALL_LIMIT  = 3000;
    localparam int              LONG_HOLD    = 400;
    localparam int              DRAIN_CYCLES = 80;
    localparam int              REPORT_MAX   = 10;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        data_byte;
        logic              last;
        logic [15:0]       seq_query;
        logic [3:0]        slot_sel;
        logic [10:0]       byte_offset;
    } command_t;

    typedef struct packed {
        logic        status;
        logic [15:0] seq_out;
        logic [3:0]  slot_out;
        logic [11:0] length_out;
        logic [7:0]  byte_out;
    } answer_t;

    function automatic string answer_text(answer_t a);
        return $sformatf("status=%0d seq=%0d slot=%0d length=%0d byte=0x%02h",
                         a.status, a.seq_out, a.slot_out, a.length_out, a.byte_out);
    endfunction

    // Mirrors the slot table and packet memory, and queues the answers
    // that the accepted commands must produce, oldest first.
    class ring_store_tracker;
        logic [15:0] slot_number [SLOTS];
        logic [11:0] slot_length [SLOTS];
        logic [7:0]  packet_bytes [SLOTS][PKT_BYTES];
        logic [15:0] latest_number;
        logic [3:0]  write_slot;
        logic [11:0] fill_count;
        bit          in_packet;
        answer_t     pending_answers [$];
        int          failures;
        int          checked;
        int          packets;
        int          queries;
        int          wraps;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_number[i] = '0;
                slot_length[i] = '0;
            end
            latest_number = '0;
            write_slot    = '0;
            fill_count    = '0;
            in_packet     = 1'b0;
            failures      = 0;
            checked       = 0;
            packets       = 0;
            queries       = 0;
            wraps         = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function void take_command(command_t c);
            answer_t     a;
            bit          found;
            logic [15:0] best;
            a     = '0;
            found = 1'b0;
            best  = '0;
            case (c.mode)
                MODE_PUT: begin
                    if (!in_packet) begin
                        // Reaching the limit empties the whole table and restarts at 0.
                        if (latest_number == SEQ_LIMIT - 1) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                slot_number[i] = '0;
                                slot_length[i] = '0;
                            end
                            latest_number = '0;
                            write_slot    = '0;
                            wraps++;
                        end else begin
                            latest_number++;
                        end
                        fill_count = '0;
                        in_packet  = 1'b1;
                    end
                    if (fill_count < PKT_BYTES) begin
                        packet_bytes[write_slot][fill_count] = c.data_byte;
                        fill_count++;
                    end
                    if (c.last) begin
                        slot_number[write_slot] = latest_number;
                        slot_length[write_slot] = fill_count;
                        write_slot = write_slot + 1'b1;
                        fill_count = '0;
                        in_packet  = 1'b0;
                        a.status   = STAT_OK;
                        a.seq_out  = latest_number;
                        pending_answers.push_back(a);
                        packets++;
                    end
                end
                MODE_NEXT: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_number[i] > c.seq_query && (!found || slot_number[i] < best)) begin
                            best  = slot_number[i];
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        a.status  = STAT_OK;
                        a.seq_out = best;
                    end else begin
                        a.status  = STAT_NONE;
                        a.seq_out = 16'(SEQ_LIMIT);
                    end
                    pending_answers.push_back(a);
                    queries++;
                end
                MODE_LOOKUP: begin
                    a.status = STAT_NONE;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && slot_number[i] == c.seq_query) begin
                            found        = 1'b1;
                            a.status     = STAT_OK;
                            a.slot_out   = 4'(i);
                            a.length_out = slot_length[i];
                        end
                    end
                    pending_answers.push_back(a);
                    queries++;
                end
                default: begin
                    if (c.byte_offset < slot_length[c.slot_sel]) begin
                        a.status   = STAT_OK;
                        a.byte_out = packet_bytes[c.slot_sel][c.byte_offset];
                    end else begin
                        a.status = STAT_NONE;
                    end
                    pending_answers.push_back(a);
                    queries++;
                end
            endcase
        endfunction

        function void match_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result item: %s", answer_text(got));
                return;
            end
            want = pending_answers.pop_front();
            checked++;
            if (got.status !== want.status || got.seq_out !== want.seq_out ||
                got.slot_out !== want.slot_out || got.length_out !== want.length_out ||
                got.byte_out !== want.byte_out) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result %0d mismatch: expected %s, got %s",
                             checked, answer_text(want), answer_text(got));
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0]      s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    ring_store_tracker      tracker;
    bit                     sender_idles   = 1'b1;
    bit                     receiver_idles = 1'b1;
    bit                     hold_request   = 1'b0;
    int                     quiet_cycles   = 0;

    numbered_packet_ring_store_unit #(
        .SLOTS     (SLOTS),
        .PKT_BYTES (PKT_BYTES),
        .SEQ_LIMIT (SEQ_LIMIT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Fields that the mode ignores carry random values.
    function automatic command_t noise_fields();
        command_t c;
        c.mode        = MODE_W'($urandom_range(0, 3));
        c.data_byte   = 8'($urandom);
        c.last        = 1'($urandom);
        c.seq_query   = 16'($urandom);
        c.slot_sel    = 4'($urandom);
        c.byte_offset = 11'($urandom);
        return c;
    endfunction

    function automatic command_t put_cmd(logic [7:0] b, logic l);
        command_t c;
        c           = noise_fields();
        c.mode      = MODE_PUT;
        c.data_byte = b;
        c.last      = l;
        return c;
    endfunction

    function automatic command_t next_cmd(logic [15:0] q);
        command_t c;
        c           = noise_fields();
        c.mode      = MODE_NEXT;
        c.seq_query = q;
        return c;
    endfunction

    function automatic command_t lookup_cmd(logic [15:0] q);
        command_t c;
        c           = noise_fields();
        c.mode      = MODE_LOOKUP;
        c.seq_query = q;
        return c;
    endfunction

    function automatic command_t read_cmd(logic [3:0] sel, logic [10:0] off);
        command_t c;
        c             = noise_fields();
        c.mode        = MODE_READ;
        c.slot_sel    = sel;
        c.byte_offset = off;
        return c;
    endfunction

    // Queries aimed mostly at numbers and bytes that are actually stored.
    function automatic command_t shaped_query();
        int          s;
        logic [15:0] num;
        logic [11:0] len;
        logic [10:0] off;
        s   = $urandom_range(0, SLOTS - 1);
        num = tracker.slot_number[s];
        len = tracker.slot_length[s];
        case ($urandom_range(0, 2))
            0: begin
                if ($urandom_range(0, 4) == 0)
                    num = 16'($urandom);
                else
                    num = num + 16'($urandom_range(0, 2)) - 16'd1;
                return next_cmd(num);
            end
            1: begin
                if ($urandom_range(0, 4) == 0)
                    num = 16'($urandom);
                return lookup_cmd(num);
            end
            default: begin
                if (len != 0 && $urandom_range(0, 3) != 0)
                    off = 11'($urandom_range(0, len - 1));
                else if ($urandom_range(0, 1) == 0)
                    off = 11'(len);
                else
                    off = 11'($urandom);
                return read_cmd(4'(s), off);
            end
        endcase
    endfunction

    task automatic send_item(command_t c);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.byte_offset, c.slot_sel, c.seq_query, c.data_byte};
        s_tuser  <= c.mode;
        s_tlast  <= c.last;
        do @(posedge aclk); while (!s_tready);
        tracker.take_command(c);
    endtask

    task automatic send_packet(int len, bit mixed);
        for (int k = 0; k < len; k++) begin
            send_item(put_cmd(8'($urandom), k == len - 1));
            if (mixed && k != len - 1 && $urandom_range(0, 9) == 0)
                send_item(shaped_query());
        end
    endtask

    task automatic random_section(int units, bit vary_idling);
        int pick;
        for (int u = 0; u < units; u++) begin
            if (vary_idling && u % 30 == 0) begin
                sender_idles   = ($urandom_range(0, 2) != 0);
                receiver_idles = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                       : $urandom_range(1, 4), 1'b1);
            else if (pick < 88)
                send_item(shaped_query());
            else
                send_item(noise_fields());
        end
    endtask

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge aclk);
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_answer('{status: m_tuser, seq_out: m_tdata[15:0],
                                   slot_out: m_tdata[19:16], length_out: m_tdata[31:20],
                                   byte_out: m_tdata[39:32]});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: every slot holds number 0 with length 0.
        send_item(read_cmd(4'd0, 11'd0));
        send_item(read_cmd(4'd15, 11'd2047));
        send_item(next_cmd(16'd0));
        send_item(next_cmd(16'hFFFF));
        send_item(lookup_cmd(16'd0));
        send_item(lookup_cmd(16'hFFFF));
        send_item(put_cmd(8'h00, 1'b0));
        send_item(put_cmd(8'hFF, 1'b0));
        send_item(put_cmd(8'hA5, 1'b1));
        send_item(put_cmd(8'hFF, 1'b1));
        send_item(read_cmd(4'd0, 11'd0));
        send_item(read_cmd(4'd0, 11'd2));
        send_item(read_cmd(4'd0, 11'd3));
        send_item(read_cmd(4'd1, 11'd0));
        send_item(next_cmd(16'd0));
        send_item(next_cmd(16'd1));
        send_item(lookup_cmd(16'd2));
        send_item(lookup_cmd(16'd0));
        // Queries in the middle of a packet see only committed entries.
        send_item(put_cmd(8'h5A, 1'b0));
        send_item(lookup_cmd(16'd3));
        send_item(read_cmd(4'd2, 11'd0));
        send_item(read_cmd(4'd0, 11'd1));
        send_item(put_cmd(8'hC3, 1'b1));
        send_item(read_cmd(4'd2, 11'd1));

        random_section(70, 1'b1);
        hold_request = 1'b1;
        random_section(50, 1'b1);
        random_section(30, 1'b1);

        // The last part runs without idling on either side.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        random_section(20, 1'b0);

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d committed packets and %0d queries; %0d result items checked.",
                 tracker.packets, tracker.queries, tracker.checked);
        $display("Included mid-packet queries, a long output stall and %0d number wrap(s).",
                 tracker.wraps);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/npr_pkg.sv
design/npr_slot_tab.sv
design/numbered_packet_ring_store_unit.sv
design/npr_checker.sv
tb/testbench.sv
